/* rtl/fmk_pkg.sv */
// Package for the flight mode key controller.
// Holds the mode encoding, key codes, item and result structs and register indexes.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
package fmk_pkg;

	typedef enum logic [1:0] {
		FM_SAFE   = 2'd0,
		FM_PANIC  = 2'd1,
		FM_MANUAL = 2'd2
	} mode_t;

	localparam int NUM_MOTORS = 4;
	localparam int MOTOR_W = 15;
	localparam int LEVEL_W = 12;
	localparam int DELAY_W = 16;
	localparam int KEY_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 72;

	localparam logic [MOTOR_W-1:0] MOTOR_MAX = 15'd32767;
	localparam logic [MOTOR_W-1:0] MOTOR_STEP = 15'd10;
	localparam logic [MOTOR_W-1:0] PANIC_RPM = 15'd175;

	localparam logic OP_KEY = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [KEY_W-1:0] KEY_DIGIT_BASE = 8'd48;
	localparam logic [KEY_W-1:0] KEY_ESCAPE = 8'd27;
	localparam logic [KEY_W-1:0] KEY_ZERO = 8'd48;
	localparam logic [KEY_W-1:0] KEY_ONE = 8'd49;
	localparam logic [KEY_W-1:0] KEY_TWO = 8'd50;
	localparam logic [KEY_W-1:0] KEY_BATTERY = 8'd116;
	localparam logic [KEY_W-1:0] KEY_NOP_LOW = 8'd65;
	localparam logic [KEY_W-1:0] KEY_NOP_HIGH = 8'd68;

	localparam logic [KEY_W-1:0] KEY_UP [NUM_MOTORS] = '{8'd113, 8'd119, 8'd101, 8'd114};
	localparam logic [KEY_W-1:0] KEY_DOWN [NUM_MOTORS] = '{8'd97, 8'd115, 8'd100, 8'd102};

	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATTERY_WARNING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PANIC_DELAY = 2'd2;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 12'd580;
	localparam logic [LEVEL_W-1:0] WARNING_RESET = 12'd600;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd2000;

	typedef struct packed {
		logic [LEVEL_W-1:0] battery_threshold;
		logic [LEVEL_W-1:0] battery_warning_level;
		logic [DELAY_W-1:0] panic_delay_ticks;
	} cfg_t;

	typedef struct packed {
		logic               operation;
		logic [KEY_W-1:0]   key_code;
		logic [LEVEL_W-1:0] battery_level;
	} item_t;

	typedef struct packed {
		logic               exit_request;
		logic               battery_warn;
		logic               red_led;
		logic [MOTOR_W-1:0] motor_three;
		logic [MOTOR_W-1:0] motor_two;
		logic [MOTOR_W-1:0] motor_one;
		logic [MOTOR_W-1:0] motor_zero;
		mode_t              current_mode;
	} result_t;

endpackage

/* rtl/fmk_cfg.sv */
// Configuration registers of the flight mode key controller.
// Decodes writes on the configuration channel; uses fmk_pkg.
module fmk_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [fmk_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [fmk_pkg::CFG_DATA_W-1:0]   wr_data,
	output fmk_pkg::cfg_t                    cfg
);

	fmk_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.battery_threshold <= fmk_pkg::THRESHOLD_RESET;
			cfg_q.battery_warning_level <= fmk_pkg::WARNING_RESET;
			cfg_q.panic_delay_ticks <= fmk_pkg::DELAY_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				fmk_pkg::REG_BATTERY_THRESHOLD: begin
					cfg_q.battery_threshold <= wr_data[fmk_pkg::LEVEL_W-1:0];
				end
				fmk_pkg::REG_BATTERY_WARNING: begin
					cfg_q.battery_warning_level <= wr_data[fmk_pkg::LEVEL_W-1:0];
				end
				fmk_pkg::REG_PANIC_DELAY: begin
					cfg_q.panic_delay_ticks <= wr_data[fmk_pkg::DELAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/fmk_ctrl.sv */
// Mode state and next-state logic of the flight mode key controller.
// Applies one item per step and presents the resulting outputs; uses fmk_pkg.
module fmk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  fmk_pkg::item_t     item,
	input  fmk_pkg::cfg_t      cfg,
	output fmk_pkg::result_t   res
);

	fmk_pkg::mode_t                    mode_q, mode_d;
	logic [fmk_pkg::MOTOR_W-1:0]       motor_q [fmk_pkg::NUM_MOTORS];
	logic [fmk_pkg::MOTOR_W-1:0]       motor_d [fmk_pkg::NUM_MOTORS];
	logic [fmk_pkg::MOTOR_W-1:0]       motor_up [fmk_pkg::NUM_MOTORS];
	logic [fmk_pkg::MOTOR_W-1:0]       motor_dn [fmk_pkg::NUM_MOTORS];
	logic [fmk_pkg::NUM_MOTORS-1:0]    up_hit, dn_hit;
	logic [fmk_pkg::DELAY_W-1:0]       cnt_q, cnt_d, cnt_inc;
	logic                              led_q, led_d;
	logic                              exit_q, exit_d;
	logic                              warn;
	logic                              same_mode;
	logic [fmk_pkg::MOTOR_W:0]         up_sum [fmk_pkg::NUM_MOTORS];

	// Saturating step per motor and key decode per motor.
	always_comb begin
		for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) begin
			up_sum[i] = {1'b0, motor_q[i]} + {1'b0, fmk_pkg::MOTOR_STEP};
			motor_up[i] = (up_sum[i] > {1'b0, fmk_pkg::MOTOR_MAX}) ?
				fmk_pkg::MOTOR_MAX : up_sum[i][fmk_pkg::MOTOR_W-1:0];
			motor_dn[i] = (motor_q[i] < fmk_pkg::MOTOR_STEP) ?
				'0 : motor_q[i] - fmk_pkg::MOTOR_STEP;
			up_hit[i] = (item.key_code == fmk_pkg::KEY_UP[i]);
			dn_hit[i] = (item.key_code == fmk_pkg::KEY_DOWN[i]);
		end
	end

	assign cnt_inc = cnt_q + 16'd1;
	assign same_mode = (item.key_code == fmk_pkg::KEY_DIGIT_BASE + {6'd0, mode_q});

	always_comb begin
		mode_d = mode_q;
		motor_d = motor_q;
		cnt_d = cnt_q;
		led_d = led_q;
		exit_d = exit_q;
		warn = 1'b0;
		if (item.operation == fmk_pkg::OP_TICK) begin
			if (mode_q == fmk_pkg::FM_PANIC) begin
				cnt_d = cnt_inc;
				// A zero delay always passes the compare, so panic ends on the first tick.
				if (cnt_inc >= cfg.panic_delay_ticks || cnt_inc == '0) begin
					mode_d = fmk_pkg::FM_SAFE;
					for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) motor_d[i] = '0;
					cnt_d = '0;
				end
			end
		end else if (!same_mode) begin
			unique case (mode_q)
				fmk_pkg::FM_SAFE: begin
					priority if (item.key_code == fmk_pkg::KEY_TWO) begin
						mode_d = fmk_pkg::FM_MANUAL;
					end else if (item.key_code == fmk_pkg::KEY_ONE ||
							item.key_code == fmk_pkg::KEY_ZERO) begin
					end else if (item.key_code == fmk_pkg::KEY_ESCAPE) begin
						exit_d = 1'b1;
					end else begin
						led_d = ~led_q;
					end
				end
				fmk_pkg::FM_MANUAL: begin
					priority if ((|up_hit) || (|dn_hit)) begin
						for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) begin
							if (up_hit[i]) motor_d[i] = motor_up[i];
							if (dn_hit[i]) motor_d[i] = motor_dn[i];
						end
					end else if (item.key_code == fmk_pkg::KEY_BATTERY) begin
						if (item.battery_level < cfg.battery_threshold) begin
							mode_d = fmk_pkg::FM_PANIC;
							for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) begin
								motor_d[i] = fmk_pkg::PANIC_RPM;
							end
							cnt_d = '0;
						end else if (item.battery_level < cfg.battery_warning_level) begin
							warn = 1'b1;
						end
					end else if (item.key_code == fmk_pkg::KEY_ZERO) begin
						mode_d = fmk_pkg::FM_SAFE;
						for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) motor_d[i] = '0;
						cnt_d = '0;
					end else if (item.key_code == fmk_pkg::KEY_ONE) begin
						mode_d = fmk_pkg::FM_PANIC;
						for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) begin
							motor_d[i] = fmk_pkg::PANIC_RPM;
						end
						cnt_d = '0;
					end else if (item.key_code >= fmk_pkg::KEY_NOP_LOW &&
							item.key_code <= fmk_pkg::KEY_NOP_HIGH) begin
					end else begin
						led_d = ~led_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fmk_pkg::FM_SAFE;
			for (int i = 0; i < fmk_pkg::NUM_MOTORS; i++) motor_q[i] <= '0;
			cnt_q <= '0;
			led_q <= 1'b0;
			exit_q <= 1'b0;
		end else if (step) begin
			mode_q <= mode_d;
			motor_q <= motor_d;
			cnt_q <= cnt_d;
			led_q <= led_d;
			exit_q <= exit_d;
		end
	end

	always_comb begin
		res.current_mode = mode_d;
		res.motor_zero = motor_d[0];
		res.motor_one = motor_d[1];
		res.motor_two = motor_d[2];
		res.motor_three = motor_d[3];
		res.red_led = led_d;
		res.battery_warn = warn;
		res.exit_request = exit_d;
	end

endmodule

/* rtl/flight_mode_key_controller.sv */
// Top level of the flight mode key controller.
// Input register, output register and handshakes; uses fmk_pkg, fmk_cfg and fmk_ctrl.
//
// Items arrive on the s_axis channel: tuser carries the operation (key event or
// one millisecond tick), tdata the key code and battery sample. Every item gives
// exactly one result on the m_axis channel with the mode, the four motor
// setpoints, the LED level, the battery warning and the exit flag.
// An accepted item is held in the input register, where it is applied to the mode
// state; its result is loaded into the output register when that register is empty
// or being read, which raises m_axis_tvalid.
// Throughput is one item per cycle unless the receiver stalls; the update is a
// single compare and add per motor and counter between input and output registers.
// When the receiver stalls, the output register holds its result and the input
// register holds one more item; s_axis_tready falls only when both are full.
// Registers are written on the cfg channel, which is always ready; write them
// only while no item is in flight.
// Reset puts the block in safe mode with the motors at zero, LED and exit flag
// cleared, the registers at their defaults and both item registers empty.
module flight_mode_key_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// key_code [7:0], battery_level [19:8], zero fill [23:20]
	input  logic [fmk_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// operation [0]
	input  logic                                 s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// current_mode [1:0], motor_zero [16:2], motor_one [31:17], motor_two [46:32],
	// motor_three [61:47], red_led [62], battery_warn [63], exit_request [64],
	// zero fill [71:65]
	output logic [fmk_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fmk_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fmk_pkg::CFG_DATA_W-1:0]       cfg_data
);

	fmk_pkg::cfg_t     cfg;
	fmk_pkg::item_t    item_s1;
	logic              valid_s1;
	fmk_pkg::result_t  res;
	fmk_pkg::result_t  res_q;
	logic              out_valid_q;
	logic              advance;

	assign cfg_ready = 1'b1;

	fmk_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.operation <= s_axis_tuser;
			item_s1.key_code <= s_axis_tdata[7:0];
			item_s1.battery_level <= s_axis_tdata[19:8];
		end
	end

	fmk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				res_q <= res;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, res_q};

`ifndef SYNTHESIS
	a_panic_motors: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.current_mode == fmk_pkg::FM_PANIC |->
			res_q.motor_zero == fmk_pkg::PANIC_RPM && res_q.motor_one == fmk_pkg::PANIC_RPM &&
			res_q.motor_two == fmk_pkg::PANIC_RPM && res_q.motor_three == fmk_pkg::PANIC_RPM)
		else $error("panic result without all motors at panic speed");

	a_safe_motors: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.current_mode == fmk_pkg::FM_SAFE |->
			res_q.motor_zero == '0 && res_q.motor_one == '0 &&
			res_q.motor_two == '0 && res_q.motor_three == '0)
		else $error("safe result with a running motor");

	a_exit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(res_q.exit_request))
		else $error("exit flag cleared after being set");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("blocked input item lost or changed");
`endif

endmodule

/* tb/sv/tb_flight_mode_key_controller.sv */
// Self-checking testbench for flight_mode_key_controller: directed and random key and tick items.
// A behavioral model of the mode controller predicts each result; a monitor checks them in order.
// Depends on fmk_pkg and the flight_mode_key_controller RTL.
module tb_flight_mode_key_controller;
	import fmk_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD_CYCLES = 80;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_axis_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	item_t   pending_items[$];
	result_t predicted_results[$];

	mode_t              ctrl_mode = FM_SAFE;
	logic [MOTOR_W-1:0] motors [NUM_MOTORS] = '{default: '0};
	logic [DELAY_W-1:0] panic_ticks = '0;
	logic               red_led = 1'b0;
	logic               exit_flag = 1'b0;
	logic [LEVEL_W-1:0] threshold_reg = THRESHOLD_RESET;
	logic [LEVEL_W-1:0] warning_reg = WARNING_RESET;
	logic [DELAY_W-1:0] delay_reg = DELAY_RESET;

	int send_gap_pct = 30;
	int recv_stall_pct = 30;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_left = 0;
	int holds_requested = 0;
	int holds_served = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	flight_mode_key_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void enter_mode(input mode_t m);
		int i;
		ctrl_mode = m;
		for (i = 0; i < NUM_MOTORS; i++)
			motors[i] = (m == FM_PANIC) ? PANIC_RPM : '0;
		panic_ticks = '0;
	endfunction

	function automatic result_t advance_controller(input logic op, input logic [KEY_W-1:0] key,
			input logic [LEVEL_W-1:0] level);
		result_t res;
		logic    warn;
		logic    handled;
		int      i;
		warn = 1'b0;
		handled = 1'b0;
		if (op == OP_TICK) begin
			if (ctrl_mode == FM_PANIC) begin
				panic_ticks = panic_ticks + 1'b1;
				if (panic_ticks >= delay_reg || panic_ticks == '0)
					enter_mode(FM_SAFE);
			end
		end else if (8'(key - KEY_DIGIT_BASE) != {6'd0, ctrl_mode}) begin
			if (ctrl_mode == FM_SAFE) begin
				if (key == KEY_TWO)
					ctrl_mode = FM_MANUAL;
				else if (key == KEY_ESCAPE)
					exit_flag = 1'b1;
				else if (key != KEY_ONE && key != KEY_ZERO)
					red_led = ~red_led;
			end else if (ctrl_mode == FM_MANUAL) begin
				for (i = 0; i < NUM_MOTORS; i++) begin
					if (key == KEY_UP[i]) begin
						motors[i] = (motors[i] > MOTOR_MAX - MOTOR_STEP) ? MOTOR_MAX :
							motors[i] + MOTOR_STEP;
						handled = 1'b1;
					end else if (key == KEY_DOWN[i]) begin
						motors[i] = (motors[i] < MOTOR_STEP) ? '0 : motors[i] - MOTOR_STEP;
						handled = 1'b1;
					end
				end
				if (!handled) begin
					if (key == KEY_BATTERY) begin
						if (level < threshold_reg)
							enter_mode(FM_PANIC);
						else if (level < warning_reg)
							warn = 1'b1;
					end else if (key == KEY_ZERO)
						enter_mode(FM_SAFE);
					else if (key == KEY_ONE)
						enter_mode(FM_PANIC);
					else if (key < KEY_NOP_LOW || key > KEY_NOP_HIGH)
						red_led = ~red_led;
				end
			end
		end
		res.current_mode = ctrl_mode;
		res.motor_zero = motors[0];
		res.motor_one = motors[1];
		res.motor_two = motors[2];
		res.motor_three = motors[3];
		res.red_led = red_led;
		res.battery_warn = warn;
		res.exit_request = exit_flag;
		return res;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got)
			note_mismatch($sformatf("mismatch in %s: expected %0d, actual %0d", name, want, got));
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			send_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predicted_results.push_back(advance_controller(s_axis_tuser,
					s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: LEVEL_W]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() > 0 &&
						$urandom_range(99) < send_gap_pct) begin
					send_gap <= $urandom_range(3);
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= nxt.operation;
					s_axis_tdata <= IN_DATA_W'({nxt.battery_level, nxt.key_code});
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(result_t)-1:0];
				if (predicted_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result: expected none, actual mode %0d",
						got.current_mode));
				end else begin
					want = predicted_results.pop_front();
					check_field("current_mode", want.current_mode, got.current_mode);
					check_field("motor_zero", want.motor_zero, got.motor_zero);
					check_field("motor_one", want.motor_one, got.motor_one);
					check_field("motor_two", want.motor_two, got.motor_two);
					check_field("motor_three", want.motor_three, got.motor_three);
					check_field("red_led", want.red_led, got.red_led);
					check_field("battery_warn", want.battery_warn, got.battery_warn);
					check_field("exit_request", want.exit_request, got.exit_request);
				end
			end
			if (holds_served != holds_requested) begin
				holds_served <= holds_requested;
				hold_left <= LONG_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < recv_stall_pct) begin
				recv_gap <= $urandom_range(3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_item(input logic op, input logic [KEY_W-1:0] key,
			input logic [LEVEL_W-1:0] level);
		item_t it;
		it.operation = op;
		it.key_code = key;
		it.battery_level = level;
		pending_items.push_back(it);
	endtask

	task automatic push_key(input logic [KEY_W-1:0] key, input logic [LEVEL_W-1:0] level = '0);
		push_item(OP_KEY, key, level);
	endtask

	task automatic push_tick();
		push_item(OP_TICK, KEY_W'($urandom), LEVEL_W'($urandom));
	endtask

	// Mostly well-formed control traffic: motor steps, mode keys and battery checks near the
	// register levels, with ticks to leave panic and some arbitrary keys as noise.
	task automatic push_random_item();
		int unsigned        pick;
		logic [KEY_W-1:0]   key;
		logic [LEVEL_W-1:0] level;
		pick = $urandom_range(99);
		key = KEY_W'($urandom);
		level = LEVEL_W'($urandom);
		if (pick < 20) begin
			push_tick();
		end else begin
			if (pick < 50)
				key = $urandom_range(1) ? KEY_UP[$urandom_range(3)] : KEY_DOWN[$urandom_range(3)];
			else if (pick < 58)
				key = KEY_TWO;
			else if (pick < 62)
				key = KEY_ZERO;
			else if (pick < 65)
				key = KEY_ONE;
			else if (pick < 77) begin
				key = KEY_BATTERY;
				case ($urandom_range(3))
					0: level = threshold_reg - LEVEL_W'($urandom_range(1));
					1: level = warning_reg - LEVEL_W'($urandom_range(1));
					2: level = threshold_reg + LEVEL_W'($urandom_range(2));
					default: ;
				endcase
			end else if (pick < 81)
				key = KEY_ESCAPE;
			else if (pick < 87)
				key = KEY_W'($urandom_range(KEY_NOP_HIGH, KEY_NOP_LOW));
			push_key(key, level);
		end
	endtask

	task automatic push_random_items(input int count);
		int i;
		for (i = 0; i < count; i++)
			push_random_item();
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BATTERY_THRESHOLD: threshold_reg = value[LEVEL_W-1:0];
			REG_BATTERY_WARNING: warning_reg = value[LEVEL_W-1:0];
			REG_PANIC_DELAY: delay_reg = value;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_axis_tvalid || predicted_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int i;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Safe mode: LED toggles, escape, refused panic, same mode key and an idle tick.
		push_key(8'h00, 12'h000);
		push_key(8'hFF, 12'hFFF);
		push_key(KEY_ESCAPE);
		push_key(KEY_ONE);
		push_key(KEY_ZERO);
		push_tick();
		push_key(KEY_TWO);
		// Manual mode: every motor key, floor at zero, no-op keys, same mode key, LED key.
		for (i = 0; i < NUM_MOTORS; i++)
			push_key(KEY_UP[i]);
		for (i = 0; i < NUM_MOTORS; i++)
			push_key(KEY_DOWN[i]);
		push_key(KEY_DOWN[0]);
		push_key(KEY_NOP_LOW);
		push_key(KEY_NOP_HIGH);
		push_key(KEY_TWO);
		push_key("x");
		// Battery check at the warning and threshold edges, the last one enters panic.
		push_key(KEY_BATTERY, 12'd600);
		push_key(KEY_BATTERY, 12'd599);
		push_key(KEY_BATTERY, 12'd580);
		push_key(KEY_BATTERY, 12'd579);
		push_key(KEY_TWO);
		push_key(KEY_ONE);
		push_tick();
		push_tick();
		wait_drained();

		// The delay is lowered below the count already reached in panic.
		write_register(REG_PANIC_DELAY, 16'd1);
		push_tick();
		push_key(KEY_TWO);
		wait_drained();

		// A zero delay ends panic on the first tick.
		write_register(REG_PANIC_DELAY, 16'd0);
		push_key(KEY_ONE);
		push_tick();
		push_key(KEY_TWO);
		wait_drained();

		// Step every motor up twenty times and back down once.
		send_gap_pct = 0;
		recv_stall_pct = 10;
		for (i = 0; i < 20 * NUM_MOTORS; i++)
			push_key(KEY_UP[i % NUM_MOTORS]);
		for (i = 0; i < NUM_MOTORS; i++)
			push_key(KEY_DOWN[i]);
		push_key(KEY_ZERO);
		wait_drained();

		write_register(REG_BATTERY_THRESHOLD, 16'd580);
		write_register(REG_BATTERY_WARNING, 16'd600);
		write_register(REG_PANIC_DELAY, 16'd8);
		send_gap_pct = 25;
		recv_stall_pct = 25;
		push_random_items(150);
		wait_drained();

		write_register(REG_BATTERY_THRESHOLD, 16'h0000);
		write_register(REG_BATTERY_WARNING, 16'hFFFF);
		write_register(REG_PANIC_DELAY, 16'd1);
		send_gap_pct = 0;
		recv_stall_pct = 40;
		push_random_items(120);
		wait_drained();

		write_register(REG_BATTERY_THRESHOLD, 16'hFFFF);
		write_register(REG_BATTERY_WARNING, 16'h0000);
		write_register(REG_PANIC_DELAY, 16'd0);
		send_gap_pct = 40;
		recv_stall_pct = 0;
		push_random_items(120);
		wait_drained();

		write_register(REG_BATTERY_THRESHOLD, CFG_DATA_W'($urandom));
		write_register(REG_BATTERY_WARNING, CFG_DATA_W'($urandom));
		write_register(REG_PANIC_DELAY, 16'hFFFF);
		send_gap_pct = 20;
		recv_stall_pct = 20;
		push_random_items(60);
		wait_drained();

		// The receiver holds off while the sender keeps offering items.
		write_register(REG_BATTERY_THRESHOLD, CFG_DATA_W'($urandom));
		write_register(REG_BATTERY_WARNING, CFG_DATA_W'($urandom));
		write_register(REG_PANIC_DELAY, DELAY_W'($urandom_range(12, 2)));
		send_gap_pct = 30;
		recv_stall_pct = 30;
		holds_requested++;
		push_random_items(200);
		wait_drained();

		write_register(REG_BATTERY_THRESHOLD, CFG_DATA_W'($urandom_range(700, 400)));
		write_register(REG_BATTERY_WARNING, CFG_DATA_W'($urandom_range(800, 500)));
		write_register(REG_PANIC_DELAY, 16'd5);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		push_random_items(150);
		wait_drained();

		if (mismatch_count == 0 && predicted_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/fmk_pkg.sv
rtl/fmk_cfg.sv
rtl/fmk_ctrl.sv
rtl/flight_mode_key_controller.sv
tb/sv/tb_flight_mode_key_controller.sv
